// ----- hdl/dar_pkg.sv -----
// shared types and constants for the digitizer ascii record parser
package dar_pkg;

    localparam int LINE_MAX = 32;
    localparam int ADDR_W   = $clog2(LINE_MAX);
    localparam int LEN_W    = $clog2(LINE_MAX + 1);

    localparam int BYTE_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int ACC_W    = 15;
    localparam int ACC_XW   = ACC_W + 4;
    localparam int POS_W    = 17;
    localparam int BTN_W    = 4;
    localparam int FIELD_W  = 2;

    localparam int OUT_FIELDS_W = 2 * POS_W + BTN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0a;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0d;
    localparam logic [CHAR_W-1:0] CH_COMMA = 7'h2c;
    localparam logic [CHAR_W-1:0] CH_0     = 7'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 7'h39;

    localparam logic [ACC_W-1:0] ACC_SAT = 15'd32767;

    localparam logic [FIELD_W-1:0] FIELD_X     = 2'd0;
    localparam logic [FIELD_W-1:0] FIELD_Y     = 2'd1;
    localparam logic [FIELD_W-1:0] FIELD_BTN   = 2'd2;
    localparam logic [FIELD_W-1:0] FIELD_EXTRA = 2'd3;

    // floor(v * 1.862) == (v * SCALE_MULT) >> SCALE_SHIFT for every 15-bit v
    localparam int SCALE_SHIFT = 24;
    localparam int MULT_W      = 25;
    localparam int PROD_W      = ACC_W + MULT_W;
    localparam logic [MULT_W-1:0] SCALE_MULT = 25'd31239177;
    localparam logic [POS_W-1:0]  POS_OFFSET = 17'd2048;

    // one character on its way from the parser to the line compare stage
    typedef struct packed {
        logic              valid;
        logic              is_lf;
        logic              stored;
        logic [LEN_W-1:0]  idx;
        logic [CHAR_W-1:0] ch;
        logic              bad;
        logic [LEN_W-1:0]  len;
        logic [ACC_W-1:0]  acc_x;
        logic [ACC_W-1:0]  acc_y;
        logic [ACC_W-1:0]  acc_btn;
    } char_item_t;

    // raw values of a line that produces a result
    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] acc_x;
        logic [ACC_W-1:0] acc_y;
        logic [ACC_W-1:0] acc_btn;
    } raw_res_t;

    typedef struct packed {
        logic [BTN_W-1:0]        button_mask;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } result_t;

endpackage

// ----- hdl/digitizer_ascii_record_parser_top.sv -----
// top level of the digitizer ascii record parser
//
// takes one serial character per request (bit 7 ignored), hunts for the first
// line feed, then collects lines of digits, commas, cr and lf. each accepted line
// is parsed as "x,y,button" and gives one result request: pos_x and pos_y as
// floor(v*1.862)-2048 (v saturates at 32767) and the button code remapped
// 1->8, 2->4, 4->2, 8->1, anything else 0. a line with any other character, or
// longer than LINE_MAX characters including its lf, is dropped and the parser
// hunts for the next line feed again. a line identical to the last accepted line
// gives no result. empty fields are skipped, fields past the third are ignored and
// cr or lf ends a field's digits.
// rate: one character per clock while the output queue can take results. the
// line store is a pair of LINE_MAX-entry banks read once and written once per
// character, so it sets that rate. a result leaves through the compare stage,
// multiply stage and output queue once its line feed is taken. the input stalls
// only when the two-entry output queue is full and the sink is not taking results.
// no clearing pass after reset: the store is only read at entries of the last
// accepted line.
module digitizer_ascii_record_parser_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dar_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dar_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [16:0] pos_x, [33:17] pos_y,
                                                            // [37:34] button_mask, rest 0
);
    import dar_pkg::*;

    logic              en;
    logic [ADDR_W-1:0] rd_addr;
    char_item_t        item;
    raw_res_t          raw_res;
    logic              scaled_valid;
    result_t           scaled;
    logic              fifo_push;
    result_t           out_res;

    // whole pipeline moves together; it holds only when the queue cannot take more
    assign s_axis_tready = en;
    assign fifo_push     = en && scaled_valid;

    // sync, character checks and field accumulation
    dar_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .rd_addr  (rd_addr),
        .item     (item)
    );

    // line store, repeat detection and end-of-line decision
    dar_line_cmp u_line_cmp (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .rd_addr (rd_addr),
        .item    (item),
        .res     (raw_res)
    );

    // fixed-point scaling and button remap
    dar_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .res       (raw_res),
        .out_valid (scaled_valid),
        .out_data  (scaled)
    );

    // output queue parts the pipeline from the sink
    dar_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (scaled),
        .can_push  (en),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_res.button_mask, out_res.pos_y, out_res.pos_x});

endmodule

// ----- hdl/dar_front.sv -----
// character front end: line sync, validation and decimal field accumulation
module dar_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [dar_pkg::BYTE_W-1:0]  in_data,
    output logic [dar_pkg::ADDR_W-1:0]  rd_addr,
    output dar_pkg::char_item_t         item
);
    import dar_pkg::*;

    logic               accept;
    logic [CHAR_W-1:0]  c;
    logic               is_digit;
    logic               is_comma;
    logic               is_lf;
    logic               is_end;
    logic               ok_char;
    logic               len_ok;

    logic               synced_reg, synced_next;
    logic               line_bad_reg, line_bad_next;
    logic [LEN_W-1:0]   line_len_reg, line_len_next;
    logic [FIELD_W-1:0] field_idx_reg, field_idx_next;
    logic               field_open_reg, field_open_next;
    logic               field_stop_reg, field_stop_next;
    logic [ACC_W-1:0]   acc_x_reg, acc_x_next;
    logic [ACC_W-1:0]   acc_y_reg, acc_y_next;
    logic [ACC_W-1:0]   acc_btn_reg, acc_btn_next;
    char_item_t         item_reg, item_next;

    logic [ACC_W-1:0]   acc_sel;
    logic [ACC_XW-1:0]  acc_wide;
    logic [ACC_W-1:0]   acc_new;
    logic               stop_eff;

    assign accept  = en && in_valid;
    assign c       = in_data[CHAR_W-1:0];
    assign rd_addr = line_len_reg[ADDR_W-1:0];
    assign item    = item_reg;

    always_comb
    begin
        is_digit = c inside {[CH_0:CH_9]};
        is_comma = (c == CH_COMMA);
        is_lf    = (c == CH_LF);
        is_end   = (c == CH_CR) || is_lf;
        ok_char  = is_digit || is_comma || is_end;
        len_ok   = (line_len_reg < LEN_W'(LINE_MAX));

        case (field_idx_reg)
            FIELD_X: acc_sel = acc_x_reg;
            FIELD_Y: acc_sel = acc_y_reg;
            default: acc_sel = acc_btn_reg;
        endcase
        acc_wide = ACC_XW'(acc_sel) * ACC_XW'(10) + ACC_XW'(c[3:0]);
        acc_new  = (acc_wide > ACC_XW'(ACC_SAT)) ? ACC_SAT : acc_wide[ACC_W-1:0];

        synced_next     = synced_reg;
        line_bad_next   = line_bad_reg;
        line_len_next   = line_len_reg;
        field_idx_next  = field_idx_reg;
        field_open_next = field_open_reg;
        field_stop_next = field_stop_reg;
        acc_x_next      = acc_x_reg;
        acc_y_next      = acc_y_reg;
        acc_btn_next    = acc_btn_reg;
        stop_eff        = field_open_reg && field_stop_reg;

        if (synced_reg)
        begin
            line_bad_next = line_bad_reg || !ok_char || !len_ok;
            if (len_ok)
                line_len_next = line_len_reg + LEN_W'(1);

            if (is_comma)
            begin
                if (field_open_reg)
                begin
                    field_open_next = 1'b0;
                    if (field_idx_reg != FIELD_EXTRA)
                        field_idx_next = field_idx_reg + FIELD_W'(1);
                end
            end
            else
            begin
                field_open_next = 1'b1;
                field_stop_next = stop_eff;
                if (is_end)
                    field_stop_next = 1'b1;
                else if (is_digit && !stop_eff)
                begin
                    case (field_idx_reg)
                        FIELD_X:   acc_x_next   = acc_new;
                        FIELD_Y:   acc_y_next   = acc_new;
                        FIELD_BTN: acc_btn_next = acc_new;
                        default:   ;
                    endcase
                end
            end
        end

        item_next         = '0;
        item_next.valid   = accept && synced_reg;
        item_next.is_lf   = is_lf;
        item_next.stored  = len_ok;
        item_next.idx     = line_len_reg;
        item_next.ch      = c;
        item_next.bad     = line_bad_next;
        item_next.len     = line_len_next;
        item_next.acc_x   = acc_x_next;
        item_next.acc_y   = acc_y_next;
        item_next.acc_btn = acc_btn_next;

        // line feed closes the line (or ends the sync hunt) and starts afresh
        if (is_lf)
        begin
            synced_next     = synced_reg ? !line_bad_next : 1'b1;
            line_bad_next   = 1'b0;
            line_len_next   = '0;
            field_idx_next  = FIELD_X;
            field_open_next = 1'b0;
            field_stop_next = 1'b0;
            acc_x_next      = '0;
            acc_y_next      = '0;
            acc_btn_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg     <= 1'b0;
            line_bad_reg   <= 1'b0;
            line_len_reg   <= '0;
            field_idx_reg  <= FIELD_X;
            field_open_reg <= 1'b0;
            field_stop_reg <= 1'b0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            acc_btn_reg    <= '0;
            item_reg       <= '0;
        end
        else if (en)
        begin
            item_reg <= item_next;
            if (accept)
            begin
                synced_reg     <= synced_next;
                line_bad_reg   <= line_bad_next;
                line_len_reg   <= line_len_next;
                field_idx_reg  <= field_idx_next;
                field_open_reg <= field_open_next;
                field_stop_reg <= field_stop_next;
                acc_x_reg      <= acc_x_next;
                acc_y_reg      <= acc_y_next;
                acc_btn_reg    <= acc_btn_next;
            end
        end
    end

endmodule

// ----- hdl/dar_line_cmp.sv -----
// two-bank line store with repeat-line detection and end-of-line decision
module dar_line_cmp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [dar_pkg::ADDR_W-1:0] rd_addr,
    input  dar_pkg::char_item_t        item,
    output dar_pkg::raw_res_t          res
);
    import dar_pkg::*;

    logic [CHAR_W-1:0] mem0 [LINE_MAX];
    logic [CHAR_W-1:0] mem1 [LINE_MAX];
    logic [CHAR_W-1:0] q0_reg;
    logic [CHAR_W-1:0] q1_reg;

    logic              bank_sel_reg, bank_sel_next;
    logic              prev_valid_reg, prev_valid_next;
    logic [LEN_W-1:0]  prev_len_reg, prev_len_next;
    logic              differs_reg, differs_next;

    // bypass for a read issued in the same cycle as the write to that entry
    logic              fwd_valid_reg;
    logic              fwd_bank_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [CHAR_W-1:0] fwd_data_reg;

    logic              prv;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic [CHAR_W-1:0] rd_data;
    logic              cmp_diff;
    logic              diff_now;
    logic              line_new;
    logic              fire;

    assign wr_addr = item.idx[ADDR_W-1:0];
    assign wr_en   = item.valid && item.stored;

    always_comb
    begin
        prv = ~bank_sel_reg;
        rd_data = prv ? q1_reg : q0_reg;
        if (fwd_valid_reg && (fwd_bank_reg == prv) && (fwd_addr_reg == wr_addr))
            rd_data = fwd_data_reg;

        cmp_diff = item.stored &&
                   (!prev_valid_reg || (item.idx >= prev_len_reg) || (rd_data != item.ch));
        diff_now = differs_reg || cmp_diff;
        line_new = diff_now || !prev_valid_reg || (item.len != prev_len_reg);
        fire     = item.valid && item.is_lf && !item.bad && line_new;

        res.valid   = fire;
        res.acc_x   = item.acc_x;
        res.acc_y   = item.acc_y;
        res.acc_btn = item.acc_btn;

        bank_sel_next   = bank_sel_reg;
        prev_valid_next = prev_valid_reg;
        prev_len_next   = prev_len_reg;
        differs_next    = differs_reg;
        if (item.valid)
            differs_next = item.is_lf ? 1'b0 : diff_now;
        if (fire)
        begin
            bank_sel_next   = prv;
            prev_valid_next = 1'b1;
            prev_len_next   = item.len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg <= mem0[rd_addr];
            q1_reg <= mem1[rd_addr];
            if (wr_en)
            begin
                if (bank_sel_reg)
                    mem1[wr_addr] <= item.ch;
                else
                    mem0[wr_addr] <= item.ch;
            end
            fwd_bank_reg <= bank_sel_reg;
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= item.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_sel_reg   <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_len_reg   <= '0;
            differs_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            bank_sel_reg   <= bank_sel_next;
            prev_valid_reg <= prev_valid_next;
            prev_len_reg   <= prev_len_next;
            differs_reg    <= differs_next;
            fwd_valid_reg  <= wr_en;
        end
    end

endmodule

// ----- hdl/dar_scale.sv -----
// coordinate scaling multiply stage and button remap
module dar_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  dar_pkg::raw_res_t   res,
    output logic                out_valid,
    output dar_pkg::result_t    out_data
);
    import dar_pkg::*;

    logic              valid_reg;
    logic [PROD_W-1:0] prod_x_reg;
    logic [PROD_W-1:0] prod_y_reg;
    logic [BTN_W-1:0]  btn_reg;
    logic [BTN_W-1:0]  btn_next;

    always_comb
    begin
        case (res.acc_btn)
            ACC_W'(1): btn_next = BTN_W'(8);
            ACC_W'(2): btn_next = BTN_W'(4);
            ACC_W'(4): btn_next = BTN_W'(2);
            ACC_W'(8): btn_next = BTN_W'(1);
            default:   btn_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= PROD_W'(res.acc_x) * PROD_W'(SCALE_MULT);
            prod_y_reg <= PROD_W'(res.acc_y) * PROD_W'(SCALE_MULT);
            btn_reg    <= btn_next;
        end
    end

    assign out_valid            = valid_reg;
    assign out_data.pos_x       = $signed(POS_W'(prod_x_reg[PROD_W-1:SCALE_SHIFT]) - POS_OFFSET);
    assign out_data.pos_y       = $signed(POS_W'(prod_y_reg[PROD_W-1:SCALE_SHIFT]) - POS_OFFSET);
    assign out_data.button_mask = btn_reg;

endmodule

// ----- hdl/dar_out_fifo.sv -----
// two-entry result queue in front of the output port
module dar_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dar_pkg::result_t  push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output dar_pkg::result_t  out_data
);
    import dar_pkg::*;

    result_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign can_push  = (count_reg != 2'd2) || out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (!push && pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

// ----- dv/digitizer_ascii_record_parser_top_tb.sv -----
// self-checking testbench for the digitizer ascii record parser top level
`timescale 1ns / 1ps

module digitizer_ascii_record_parser_top_tb;

    import dar_pkg::*;

    localparam int LMAX          = LINE_MAX;
    localparam int STALL_LIMIT   = 2000;    // cycles with no request taken on either side
    localparam int DRAIN_CYCLES  = 12;      // settling time after the last record is returned
    localparam int RANDOM_CHARS  = 1100;
    localparam int unsigned SCALE_NUM    = 1862;
    localparam int unsigned SCALE_DEN    = 1000;
    localparam int unsigned COORD_OFFSET = 2048;
    localparam int unsigned VALUE_SAT    = 32767;
    localparam string CR_TXT = "\015";

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    digitizer_ascii_record_parser_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // characters waiting to be sent and records the parser must still produce
    logic [BYTE_W-1:0] rx_chars [$];
    result_t           record_q [$];

    int chars_taken     = 0;
    int records_seen    = 0;
    int lines_repeated  = 0;
    int lines_dropped   = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;

    // handshake pacing
    int src_hold  = 0;
    int src_mode  = 1;
    int sink_hold = 0;
    int sink_mode = 1;
    int sink_draw;

    // ------------------------------------------------------------------
    // line parser prediction: state of the line in progress and of the
    // last accepted line
    // ------------------------------------------------------------------
    bit                in_sync  = 1'b0;
    bit                cur_bad  = 1'b0;
    int                cur_len  = 0;
    bit                cur_new  = 1'b0;
    bit                wr_bank  = 1'b0;
    bit                last_ok  = 1'b0;
    int                last_len = 0;
    int                fld_idx  = 0;
    bit                fld_open = 1'b0;
    bit                fld_done = 1'b0;
    int unsigned       val_x    = 0;
    int unsigned       val_y    = 0;
    int unsigned       val_btn  = 0;
    logic [CHAR_W-1:0] line_bank [2][LMAX];

    task automatic clear_line();
        cur_bad  = 1'b0;
        cur_len  = 0;
        cur_new  = 1'b0;
        fld_idx  = 0;
        fld_open = 1'b0;
        fld_done = 1'b0;
        val_x    = 0;
        val_y    = 0;
        val_btn  = 0;
    endtask

    // decimal accumulate, saturating
    function automatic int unsigned add_digit(int unsigned acc, int unsigned digit);
        int unsigned v;
        v = acc * 10 + digit;
        return (v > VALUE_SAT) ? VALUE_SAT : v;
    endfunction

    // floor(v * 1.862) - 2048, wrapped to the port width
    function automatic logic signed [POS_W-1:0] scale_coord(int unsigned v);
        int unsigned s;
        s = (v * SCALE_NUM) / SCALE_DEN;
        return POS_W'(s - COORD_OFFSET);
    endfunction

    // tablet button code to one-hot mask, reversed bit order
    function automatic logic [BTN_W-1:0] remap_button(int unsigned b);
        case (b)
            1:       return 4'd8;
            2:       return 4'd4;
            4:       return 4'd2;
            8:       return 4'd1;
            default: return 4'd0;
        endcase
    endfunction

    task automatic parse_record_char(input logic [BYTE_W-1:0] b);
        logic [CHAR_W-1:0] c;
        bit                is_digit;
        result_t           rec;
        c = b[CHAR_W-1:0];
        is_digit = c inside {[CH_0:CH_9]};

        // hunting for the line feed that starts the first clean line
        if (!in_sync)
        begin
            if (c == CH_LF)
            begin
                in_sync = 1'b1;
                clear_line();
            end
            return;
        end

        if (!(is_digit || c == CH_COMMA || c == CH_CR || c == CH_LF))
            cur_bad = 1'b1;

        // store the character and compare against the last accepted line
        if (cur_len >= LMAX)
            cur_bad = 1'b1;
        else
        begin
            if (!last_ok || cur_len >= last_len || line_bank[!wr_bank][cur_len] != c)
                cur_new = 1'b1;
            line_bank[wr_bank][cur_len] = c;
            cur_len++;
        end

        // field split: empty fields are skipped, cr/lf stops the digits
        if (c == CH_COMMA)
        begin
            if (fld_open)
            begin
                fld_open = 1'b0;
                if (fld_idx < 3)
                    fld_idx++;
            end
        end
        else
        begin
            if (!fld_open)
            begin
                fld_open = 1'b1;
                fld_done = 1'b0;
            end
            if (c == CH_CR || c == CH_LF)
                fld_done = 1'b1;
            else if (is_digit && !fld_done)
            begin
                case (fld_idx)
                    FIELD_X:   val_x   = add_digit(val_x, c - CH_0);
                    FIELD_Y:   val_y   = add_digit(val_y, c - CH_0);
                    FIELD_BTN: val_btn = add_digit(val_btn, c - CH_0);
                    default:   ;
                endcase
            end
        end

        if (c != CH_LF)
            return;

        if (cur_bad)
        begin
            in_sync = 1'b0;
            lines_dropped++;
            clear_line();
            return;
        end
        if (!last_ok || cur_len != last_len)
            cur_new = 1'b1;
        if (!cur_new)
        begin
            lines_repeated++;
            clear_line();
            return;
        end

        rec.pos_x       = scale_coord(val_x);
        rec.pos_y       = scale_coord(val_y);
        rec.button_mask = remap_button(val_btn);
        record_q.push_back(rec);
        last_len = cur_len;
        last_ok  = 1'b1;
        wr_bank  = !wr_bank;
        clear_line();
    endtask

    // compare one result request with the oldest expected record
    task automatic check_record(input logic [OUT_TDATA_W-1:0] data);
        result_t got;
        result_t want;
        got = data[OUT_FIELDS_W-1:0];
        records_seen++;
        if (record_q.size() == 0)
        begin
            $error("unexpected record: pos_x %0d pos_y %0d button_mask %0d",
                   got.pos_x, got.pos_y, got.button_mask);
            mismatches++;
            return;
        end
        want = record_q.pop_front();
        if (got.pos_x !== want.pos_x)
        begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
            mismatches++;
        end
        if (got.pos_y !== want.pos_y)
        begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
            mismatches++;
        end
        if (got.button_mask !== want.button_mask)
        begin
            $error("button_mask: expected %0d, got %0d", want.button_mask, got.button_mask);
            mismatches++;
        end
        if (data[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
        begin
            $error("tdata padding: expected 0, got %0h", data[OUT_TDATA_W-1:OUT_FIELDS_W]);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mode 0 gives a stretch without idling, mode 1 mostly short gaps and a few long ones
    function automatic int pick_gap(int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // queue a line and its lf; msb_mode 0 clean, 1 bit 7 set at random, 2 bit 7 on all
    task automatic add_line(input string body, input int msb_mode);
        logic [BYTE_W-1:0] ch;
        for (int i = 0; i < body.len(); i++)
        begin
            ch = body[i];
            if (msb_mode == 2 || (msb_mode == 1 && $urandom_range(0, 7) == 0))
                ch[BYTE_W-1] = 1'b1;
            rx_chars.push_back(ch);
        end
        rx_chars.push_back({1'b0, CH_LF});
    endtask

    function automatic string zero_pad(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, "0"};
        return s;
    endfunction

    // decimal text of random size; an empty field now and then
    function automatic string rand_number();
        int    n;
        string s;
        n = $urandom_range(0, 19);
        if (n == 0)
            return "";
        if (n < 4)
            s = $sformatf("%0d", $urandom_range(0, 9));
        else if (n < 17)
            s = $sformatf("%0d", $urandom_range(0, 32767));
        else
            s = $sformatf("%0d", $urandom_range(0, 999999));
        if ($urandom_range(0, 9) == 0)
            s = {zero_pad($urandom_range(1, 4)), s};
        return s;
    endfunction

    function automatic string rand_sep();
        return ($urandom_range(0, 7) == 0) ? ",," : ",";
    endfunction

    string last_text = "1,1,1";

    // mostly well-formed records, some repeats, the rest noise and broken lines
    task automatic add_random_line();
        int    r;
        int    codes [5] = '{0, 1, 2, 4, 8};
        string s;
        string btn;
        r = $urandom_range(0, 99);
        if (r < 14)
        begin
            add_line(last_text, 1);
        end
        else if (r < 90)
        begin
            if ($urandom_range(0, 3) == 0)
                btn = $sformatf("%0d", $urandom_range(0, 20));
            else
                btn = $sformatf("%0d", codes[$urandom_range(0, 4)]);
            s = {rand_number(), rand_sep(), rand_number(), rand_sep(), btn};
            if ($urandom_range(0, 11) == 0)
                s = {",", s};
            if ($urandom_range(0, 11) == 0)
                s = {s, ",", rand_number()};
            if ($urandom_range(0, 11) == 0)
                s = {s, ",,"};
            if ($urandom_range(0, 11) == 0)
                s = {rand_number(), CR_TXT, rand_number(), ",", s};
            if ($urandom_range(0, 3) != 0)
                s = {s, CR_TXT};
            last_text = s;
            add_line(s, 1);
        end
        else if (r < 94)
        begin
            // raw bytes, any value
            repeat ($urandom_range(1, 20))
                rx_chars.push_back(BYTE_W'($urandom_range(0, 255)));
            rx_chars.push_back({1'b0, CH_LF});
        end
        else if (r < 97)
        begin
            // digits past the line length limit
            s = "";
            repeat ($urandom_range(LMAX, LMAX + 12))
                s = {s, "7"};
            add_line(s, 1);
        end
        else
        begin
            // one forbidden printable character in an otherwise good record
            s = $sformatf("%0d,%0d,1", $urandom_range(0, 999), $urandom_range(0, 999));
            s = {s, string'(byte'($urandom_range(8'h3a, 8'h7e)))};
            add_line(s, 0);
        end
    endtask

    // every queued character taken and every expected record returned
    task automatic wait_all_done();
        @(negedge clk);
        while (rx_chars.size() != 0 || s_axis_tvalid || record_q.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // clock, driver, monitor, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // character driver: holds a request until taken, then predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_hold      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_record_char(s_axis_tdata);
                chars_taken++;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // request stays on the bus
            end
            else if (src_hold > 0)
            begin
                s_axis_tvalid <= 1'b0;
                src_hold      <= src_hold - 1;
            end
            else if (rx_chars.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= rx_chars.pop_front();
                src_hold      <= pick_gap(src_mode);
                if ($urandom_range(0, 63) == 0)
                    src_mode <= ($urandom_range(0, 3) == 0) ? 0 : 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // record monitor with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_hold     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_record(m_axis_tdata);
            if (sink_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold     <= sink_hold - 1;
            end
            else
            begin
                sink_draw = 0;
                if ((m_axis_tvalid && m_axis_tready) || $urandom_range(0, 15) == 0)
                    sink_draw = pick_gap(sink_mode);
                if (sink_draw > 0)
                begin
                    m_axis_tready <= 1'b0;
                    sink_hold     <= sink_draw - 1;
                end
                else
                    m_axis_tready <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    sink_mode <= ($urandom_range(0, 3) == 0) ? 0 : 1;
            end
        end
    end

    // ends a hung run: too long with no request taken on either side
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("digitizer_ascii_record_parser_top_tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;

        // noise before the first line feed is thrown away, bit 7 set and clear
        rx_chars.push_back(8'hff);
        rx_chars.push_back(8'h00);
        rx_chars.push_back(8'h80);
        add_line("9,9,1", 0);

        add_line({"0,0,0", CR_TXT}, 0);                 // smallest coordinates
        add_line({"32767,32767,1", CR_TXT}, 0);         // largest unsaturated
        add_line("99999,123456,2", 0);                  // saturation, no cr
        add_line("99999,123456,2", 2);                  // repeat, bit 7 on every char
        add_line({"5,6,4", CR_TXT}, 0);
        add_line({"7,8,8", CR_TXT}, 0);
        add_line({"7,8,3", CR_TXT}, 0);                 // unknown button
        add_line({",,12,,,34,,8,,", CR_TXT}, 0);        // empty fields
        add_line({"1,2,1,77,88", CR_TXT}, 0);           // extra fields
        add_line({"12", CR_TXT, "34,56", CR_TXT, "7,2"}, 0);  // cr inside fields
        add_line("", 0);                                // bare line feed
        add_line("", 0);                                // same again, suppressed
        add_line("1,2,x", 0);                           // bad character
        add_line("3,4,1", 0);                           // eaten by the resync
        add_line("3,4,1", 0);
        add_line({zero_pad(21), "123,456,2", CR_TXT}, 0);   // exactly the line limit
        add_line({zero_pad(22), "123,456,2", CR_TXT}, 0);   // one over the limit
        add_line("5,5,8", 0);                           // eaten by the resync
        add_line("6,6,8", 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // hold the sender until the directed records are all back
        wait_all_done();

        while (rx_chars.size() < RANDOM_CHARS)
            add_random_line();

        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d characters and %0d records", chars_taken, records_seen);
        $display("%0d repeated lines suppressed, %0d bad or over-long lines dropped",
                 lines_repeated, lines_dropped);
        if (mismatches == 0 && record_q.size() == 0)
            $display("digitizer_ascii_record_parser_top_tb OK");
        else
            $display("digitizer_ascii_record_parser_top_tb NOT OK");
        $finish;
    end

endmodule
